// File: rtl/maxpool_2x2_stride2_fp16_top_assert.svh
// Assertion macros shared by the checker
`ifndef MAXPOOL_2X2_STRIDE2_FP16_TOP_ASSERT_SVH
`define MAXPOOL_2X2_STRIDE2_FP16_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define MP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define MP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/mp_pkg.sv
// ----------------------------------------------------------------------------
// mp_pkg
// Shared constants and the half-precision fmax function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mp_pkg;
  localparam logic [15:0] HALF_CANON_NAN = 16'h7E00;
  localparam int unsigned CFG_AW = 4;
  localparam logic [CFG_AW-1:0] REG_IN_WIDTH   = 4'h0;
  localparam logic [CFG_AW-1:0] REG_IN_HEIGHT  = 4'h4;
  localparam logic [CFG_AW-1:0] REG_OUT_WIDTH  = 4'h8;
  localparam logic [CFG_AW-1:0] REG_OUT_HEIGHT = 4'hC;

  function automatic logic half_is_nan(input logic [15:0] x);
    half_is_nan = (x[14:10] == 5'h1F) && (x[9:0] != 10'd0);
  endfunction

  function automatic logic [15:0] half_key(input logic [15:0] x);
    half_key = x[15] ? ~x : {1'b1, x[14:0]};
  endfunction

  // RISC-V fmax on half bits
  function automatic logic [15:0] half_max(input logic [15:0] a, input logic [15:0] b);
    logic na;
    logic nb;
    na = half_is_nan(a);
    nb = half_is_nan(b);
    if (na && nb) half_max = HALF_CANON_NAN;
    else if (na) half_max = b;
    else if (nb) half_max = a;
    else half_max = (half_key(a) >= half_key(b)) ? a : b;
  endfunction
endpackage

// File: rtl/mp_stream_if.sv
// ----------------------------------------------------------------------------
// mp_stream_if
// Valid/ready channel carrying a flat payload word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mp_stream_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/mp_lane.sv
// ----------------------------------------------------------------------------
// mp_lane
// One channel lane: pair maximum and window maximum against the row store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mp_lane (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pair_ld,
  input  logic        pair_upd,
  input  logic [15:0] sample,
  input  logic [15:0] stored,
  output logic [15:0] pair_nxt,
  output logic [15:0] win_max
);
  logic [15:0] pair_r;

  // fold the odd-column sample into the held even sample
  assign pair_nxt = mp_pkg::half_max(pair_r, sample);
  assign win_max  = mp_pkg::half_max(stored, pair_nxt);

  // hold the pair register
  always_ff @(posedge clk) begin
    if (!rst_n) pair_r <= 16'd0;
    else if (pair_ld) pair_r <= sample;
    else if (pair_upd) pair_r <= pair_nxt;
  end
endmodule

// File: rtl/maxpool_2x2_stride2_fp16_top.sv
// ----------------------------------------------------------------------------
// maxpool_2x2_stride2_fp16_top
// Streaming 2x2 stride-2 max pooling over half-precision lanes.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_*    | in  | sample_lane0..LANES-1, 16 bits each
// out_*   | out | max_lane0..LANES-1, last_of_plane
// cfg_*   | in  | APB registers in_width, in_height, out_width, out_height
// One word accepted per cycle unless a stalled result blocks input; a result shows in the next cycle.
// Row store is a single memory read one word ahead of the odd column.
// Reset clears counters, pair and valid registers and presets the config; the row store stays unwritten.
// A stalled result blocks input only when the output register is full
// and not being taken.
`timescale 1ns / 1ps
module maxpool_2x2_stride2_fp16_top #(
  parameter int unsigned LANES     = 4,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mp_stream_if.sink   in_ch,
  mp_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [mp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW    = 16 * LANES;

  logic [10:0] in_width_r, in_height_r;
  logic [9:0]  out_width_r, out_height_r;
  logic [10:0] col_r, row_r;
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;
  logic        out_valid_r;
  logic [DW:0] out_data_r;

  // register file
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r <= 11'd2; in_height_r <= 11'd2;
      out_width_r <= 10'd1; out_height_r <= 10'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        mp_pkg::REG_IN_WIDTH:   in_width_r   <= cfg_pwdata[10:0];
        mp_pkg::REG_IN_HEIGHT:  in_height_r  <= cfg_pwdata[10:0];
        mp_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_pwdata[9:0];
        mp_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      mp_pkg::REG_IN_WIDTH:   cfg_prdata = {21'd0, in_width_r};
      mp_pkg::REG_IN_HEIGHT:  cfg_prdata = {21'd0, in_height_r};
      mp_pkg::REG_OUT_WIDTH:  cfg_prdata = {22'd0, out_width_r};
      mp_pkg::REG_OUT_HEIGHT: cfg_prdata = {22'd0, out_height_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // effective sizes
  logic [13:0] w_eff, h_eff;
  logic [12:0] ow_eff, oh_eff;
  always_comb begin
    w_eff = (in_width_r < 11'd2) ? 14'd2 :
            ({3'd0, in_width_r} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'd0, in_width_r};
    h_eff = (in_height_r < 11'd2) ? 14'd2 :
            (in_height_r > 11'd1024) ? 14'd1024 : {3'd0, in_height_r};
    ow_eff = ({3'd0, out_width_r} > w_eff[13:1]) ? w_eff[13:1] : {3'd0, out_width_r};
    oh_eff = ({3'd0, out_height_r} > h_eff[13:1]) ? h_eff[13:1] : {3'd0, out_height_r};
  end

  logic accept, active, odd_c, odd_r, last;
  logic [AW-1:0] slot;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign active = ({3'd0, col_r} < {ow_eff, 1'b0}) && ({3'd0, row_r} < {oh_eff, 1'b0});
  assign odd_c  = col_r[0];
  assign odd_r  = row_r[0];
  assign slot   = AW'(col_r[10:1]);
  assign last   = ({3'd0, row_r[10:1]} == oh_eff - 13'd1) &&
                  ({3'd0, col_r[10:1]} == ow_eff - 13'd1);

  // lanes
  logic [DW-1:0] pair_w, win_w;
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mp_lane u_lane (
      .clk(clk),
      .rst_n(rst_n),
      .pair_ld(accept && active && !odd_c),
      .pair_upd(accept && active && odd_c),
      .sample(in_ch.data[16*g +: 16]),
      .stored(rd_r[16*g +: 16]),
      .pair_nxt(pair_w[16*g +: 16]),
      .win_max(win_w[16*g +: 16])
    );
  end

  // row store: write on even rows, read ahead on the even column
  always_ff @(posedge clk) begin
    if (accept && active && odd_c && !odd_r) mem[slot] <= pair_w;
    if (accept && !odd_c) rd_r <= mem[slot];
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 11'd0; row_r <= 11'd0;
    end else if (accept) begin
      if ({3'd0, col_r} + 14'd1 >= w_eff) begin
        col_r <= 11'd0;
        row_r <= ({3'd0, row_r} + 14'd1 >= h_eff) ? 11'd0 : row_r + 11'd1;
      end else begin
        col_r <= col_r + 11'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (accept) out_valid_r <= active && odd_c && odd_r;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (accept && active && odd_c && odd_r) out_data_r <= {last, win_w};
  end
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
endmodule

// File: rtl/mp_checker.sv
// ----------------------------------------------------------------------------
// mp_checker
// Port-level checks for the pooling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "maxpool_2x2_stride2_fp16_top_assert.svh"
module mp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_pready
);
  `MP_ASSERT_IMPL(a_rdy, clk, rst_n, out_valid && !out_ready, !in_ready)
  `MP_ASSERT_IMPL(a_free, clk, rst_n, !out_valid, in_ready)
  `MP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `MP_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, cfg_pready)
endmodule

bind maxpool_2x2_stride2_fp16_top mp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cfg_pready(cfg_pready)
);
